// ----- sv/resolution_weighted_blend_defines.svh -----
// Assertion macros shared by the resolution weighted blend RTL.
`ifndef RESOLUTION_WEIGHTED_BLEND_DEFINES_SVH
`define RESOLUTION_WEIGHTED_BLEND_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rwb_pkg.sv -----
// Types, codes and default parameters of the resolution weighted blend.
`default_nettype none

package rwb_pkg;

  localparam int LANE_W    = 32;
  localparam int NUM_LANES = 4;
  localparam int RES_W     = 6;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam int DEF_LANES            = 4;
  localparam int DEF_MAX_SOURCES      = 16;
  localparam int DEF_WEIGHT_FRAC_BITS = 16;

  localparam logic [MODE_W-1:0] MODE_INT_AVG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIX_AVG   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BEST_RES  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_RES   = 2'd1;

  typedef struct packed {
    logic                     sample_present;
    logic [RES_W-1:0]         source_resolution;
    logic signed [LANE_W-1:0] lane_in_0;
    logic signed [LANE_W-1:0] lane_in_1;
    logic signed [LANE_W-1:0] lane_in_2;
    logic signed [LANE_W-1:0] lane_in_3;
    logic                     last_of_cell;
  } in_word_t;

  typedef struct packed {
    logic                     has_value;
    logic signed [LANE_W-1:0] lane_out_0;
    logic signed [LANE_W-1:0] lane_out_1;
    logic signed [LANE_W-1:0] lane_out_2;
    logic signed [LANE_W-1:0] lane_out_3;
  } out_word_t;

endpackage

`default_nettype wire

// ----- sv/rwb_div.sv -----
// Restoring unsigned divider that retires one quotient bit per cycle.
`default_nettype none

module rwb_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             q_bit;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, acc[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
    rem_next = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        acc   <= num;
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_next;
        acc <= {acc[NUM_W-2:0], q_bit};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = acc;

endmodule

`default_nettype wire

// ----- sv/resolution_weighted_blend.sv -----
// Resolution weighted blend: accumulates source samples per cell, divides on the last one.
// An added sample passes the decide state, then a multiply and an add state per lane, after a
// weight division in weighted mode if the resolutions differ; the divider forms DIV_N (54 at
// the defaults) quotient bits, one per cycle. The last sample adds per-lane divisions and the emit state.
// Input is taken only while the sequencer is idle; one result word is held at the output.
// Synchronous reset clears the sequencer state, the configuration, the accumulators and the output valid.
`default_nettype none

module resolution_weighted_blend #(
  parameter int LANES            = rwb_pkg::DEF_LANES,
  parameter int MAX_SOURCES      = rwb_pkg::DEF_MAX_SOURCES,
  parameter int WEIGHT_FRAC_BITS = rwb_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rwb_pkg::in_word_t                in_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rwb_pkg::out_word_t                    out_word,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "resolution_weighted_blend_defines.svh"

  localparam int LANE_W  = rwb_pkg::LANE_W;
  localparam int RES_W   = rwb_pkg::RES_W;
  localparam int W_W     = WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W   = 33 + WEIGHT_FRAC_BITS + $clog2(MAX_SOURCES);
  localparam int DIV_N   = SUM_W + 1;
  localparam int DEN_W   = WEIGHT_FRAC_BITS + $clog2(MAX_SOURCES) + 1;
  localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
  localparam int PROD_W  = W_W + 1 + LANE_W;
  localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [W_W-1:0] W_ONE = W_W'(1) << WEIGHT_FRAC_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WDIV   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_FLANE  = 3'd5;
  localparam logic [2:0] S_FDIV   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]                   state;
  logic [LIDX_W-1:0]            lane;
  logic [rwb_pkg::MODE_W-1:0]   blend_mode;
  logic [RES_W-1:0]             view_resolution;
  rwb_pkg::in_word_t            item;

  logic signed [SUM_W-1:0]      lane_sum [LANES];
  logic [CNT_W-1:0]             sample_count;
  logic [DEN_W-1:0]             weight_total;
  logic [RES_W-1:0]             best_resolution;
  logic                         any_sample;

  logic [W_W-1:0]               mul_w;
  logic signed [PROD_W-1:0]     prod;
  logic signed [LANE_W-1:0]     res [LANES];
  logic                         fneg;

  logic signed [LANE_W-1:0]     item_lane [rwb_pkg::NUM_LANES];
  logic signed [LANE_W-1:0]     lane_x [LANES];
  logic signed [LANE_W-1:0]     res_full [rwb_pkg::NUM_LANES];

  logic                         mode_w;
  logic                         mode_b;
  logic [RES_W-1:0]             res_gap;
  logic                         do_replace;
  logic                         do_skip;
  logic                         do_add;
  logic                         wdiv_go;
  logic [2:0]                   after_sample;
  logic signed [SUM_W-1:0]      sum_sel;
  logic [SUM_W-1:0]             sum_mag;
  logic [DEN_W-1:0]             den_sel;
  logic [DEN_W-1:0]             round_add;
  logic                         fdiv_go;
  logic                         last_lane;

  logic                         div_start;
  logic [DIV_N-1:0]             div_num;
  logic [DEN_W-1:0]             div_den;
  logic                         div_done;
  logic [DIV_N-1:0]             div_quot;

  assign item_lane[0] = item.lane_in_0;
  assign item_lane[1] = item.lane_in_1;
  assign item_lane[2] = item.lane_in_2;
  assign item_lane[3] = item.lane_in_3;

  for (genvar g = 0; g < LANES; g++) begin : g_lane_x
    assign lane_x[g] = item_lane[g];
  end

  for (genvar g = 0; g < rwb_pkg::NUM_LANES; g++) begin : g_res
    if (g < LANES) begin : g_used
      assign res_full[g] = res[g];
    end else begin : g_unused
      assign res_full[g] = '0;
    end
  end

  always_comb begin
    mode_w = (blend_mode == rwb_pkg::MODE_WEIGHTED);
    mode_b = (blend_mode == rwb_pkg::MODE_BEST_RES);
    res_gap = (view_resolution > item.source_resolution) ?
              view_resolution - item.source_resolution :
              item.source_resolution - view_resolution;
    do_replace = item.sample_present && mode_b &&
                 (item.source_resolution > best_resolution);
    do_skip    = mode_b && (item.source_resolution < best_resolution);
    do_add     = item.sample_present && !do_replace && !do_skip &&
                 (sample_count < CNT_W'(MAX_SOURCES));
    wdiv_go    = do_add && mode_w && (res_gap != '0);
    after_sample = item.last_of_cell ? S_FLANE : S_IDLE;
    last_lane  = (lane == LIDX_W'(LANES - 1));

    sum_sel   = lane_sum[lane];
    sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    den_sel   = mode_w ? weight_total : DEN_W'(sample_count);
    round_add = (blend_mode == rwb_pkg::MODE_INT_AVG) ? '0 : (den_sel >> 1);
    fdiv_go   = any_sample && (den_sel != '0);

    div_start = ((state == S_DECIDE) && wdiv_go) || ((state == S_FLANE) && fdiv_go);
    if (state == S_DECIDE) begin
      div_num = DIV_N'(W_ONE + W_W'(res_gap >> 1));
      div_den = DEN_W'(res_gap);
    end else begin
      div_num = DIV_N'(sum_mag) + DIV_N'(round_add);
      div_den = den_sel;
    end
  end

  rwb_div #(
    .NUM_W(DIV_N),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      lane            <= '0;
      blend_mode      <= rwb_pkg::MODE_INT_AVG;
      view_resolution <= '0;
      sample_count    <= '0;
      weight_total    <= '0;
      best_resolution <= '0;
      any_sample      <= 1'b0;
      out_valid       <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lane_sum[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rwb_pkg::REG_BLEND_MODE: blend_mode <= cfg_data[rwb_pkg::MODE_W-1:0];
          rwb_pkg::REG_VIEW_RES:   view_resolution <= cfg_data[RES_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_word;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          lane <= '0;
          if (item.sample_present) begin
            any_sample <= 1'b1;
          end
          if (do_replace) begin
            for (int i = 0; i < LANES; i++) begin
              lane_sum[i] <= SUM_W'(lane_x[i]);
            end
            sample_count    <= CNT_W'(1);
            best_resolution <= item.source_resolution;
            state           <= after_sample;
          end else if (wdiv_go) begin
            state <= S_WDIV;
          end else if (do_add) begin
            mul_w <= mode_w ? W_ONE : W_W'(1);
            state <= S_MUL;
          end else begin
            state <= after_sample;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            mul_w <= div_quot[W_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, mul_w}) * lane_x[lane];
          state <= S_ADD;
        end
        S_ADD: begin
          lane_sum[lane] <= lane_sum[lane] + SUM_W'(prod);
          if (last_lane) begin
            sample_count <= sample_count + CNT_W'(1);
            if (mode_w) begin
              weight_total <= weight_total + DEN_W'(mul_w);
            end
            lane  <= '0;
            state <= after_sample;
          end else begin
            lane  <= lane + LIDX_W'(1);
            state <= S_MUL;
          end
        end
        S_FLANE: begin
          fneg <= sum_sel[SUM_W-1];
          if (fdiv_go) begin
            state <= S_FDIV;
          end else begin
            res[lane] <= '0;
            if (last_lane) begin
              state <= S_EMIT;
            end else begin
              lane <= lane + LIDX_W'(1);
            end
          end
        end
        S_FDIV: begin
          if (div_done) begin
            res[lane] <= fneg ? -div_quot[LANE_W-1:0] : div_quot[LANE_W-1:0];
            if (last_lane) begin
              state <= S_EMIT;
            end else begin
              lane  <= lane + LIDX_W'(1);
              state <= S_FLANE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_word.has_value  <= any_sample;
            out_word.lane_out_0 <= res_full[0];
            out_word.lane_out_1 <= res_full[1];
            out_word.lane_out_2 <= res_full[2];
            out_word.lane_out_3 <= res_full[3];
            for (int i = 0; i < LANES; i++) begin
              lane_sum[i] <= '0;
            end
            sample_count    <= '0;
            weight_total    <= '0;
            best_resolution <= '0;
            any_sample      <= 1'b0;
            lane            <= '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RWB_ASSERT(a_div_done_expected, div_done |-> (state == S_WDIV || state == S_FDIV), "divider finished outside a wait state")
  `RWB_ASSERT(a_count_bound, sample_count <= CNT_W'(MAX_SOURCES), "sample count beyond the source limit")
  `RWB_ASSERT(a_cleared_after_emit, $rose(out_valid) |-> (sample_count == '0 && !any_sample), "cell state not cleared after a result word")
  `RWB_ASSERT(a_empty_is_zero, (out_valid && !out_word.has_value) |-> (out_word.lane_out_0 == '0 && out_word.lane_out_1 == '0 && out_word.lane_out_2 == '0 && out_word.lane_out_3 == '0), "empty cell with nonzero lanes")
  `RWB_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == S_IDLE && !out_valid), "sequencer not idle after reset")

endmodule

`default_nettype wire
